[rtl/mmd_pkg.sv]
// Package for the Michael MIC digest core: shared types, codes and the
// round function of the Michael block. No dependencies.
package mmd_pkg;

    // Input item operation codes
    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_KEY_HIGH = 2'd1;

    // Padding byte appended at the end of every message
    localparam logic [7:0] MIC_PAD_BYTE = 8'h5a;

    // Word handed from the front part to the back part
    typedef struct packed {
        logic [31:0] word;
        logic        fin;
    } mmd_word_t;

    // Key register write as seen by the back part
    typedef struct packed {
        logic                   we;
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]            data;
    } mmd_key_wr_t;

    // Back part sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BLOCK1,
        ST_BLOCK2,
        ST_EMIT
    } mmd_state_t;

    // One round of the Michael block function: mix the left half into the
    // right half, then add the right half back into the left half.
    function automatic logic [63:0] mmd_round(
        input logic [31:0] l,
        input logic [31:0] r,
        input logic [1:0]  idx
    );
        logic [31:0] mix;
        logic [31:0] r_new;
        case (idx)
            2'd0:    mix = {l[14:0], l[31:15]};
            2'd1:    mix = {l[23:16], l[31:24], l[7:0], l[15:8]};
            2'd2:    mix = {l[28:0], l[31:29]};
            default: mix = {l[1:0], l[31:2]};
        endcase
        r_new = r ^ mix;
        return {l + r_new, r_new};
    endfunction

endpackage

[rtl/mmd_msg_if.sv]
// Message byte channel: valid/ready handshake carrying op and data_byte.
// Depends on nothing.
interface mmd_msg_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

[rtl/mmd_cfg_if.sv]
// Configuration write channel: valid/ready handshake with register index
// and write data. Depends on nothing.
interface mmd_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/mmd_mic_if.sv]
// MIC result channel: valid/ready handshake carrying the two 32-bit halves.
// Depends on nothing.
interface mmd_mic_if;
    logic        valid;
    logic        ready;
    logic [31:0] mic_low_word;
    logic [31:0] mic_high_word;

    modport source (output valid, output mic_low_word, output mic_high_word, input ready);
    modport sink   (input valid, input mic_low_word, input mic_high_word, output ready);
endinterface

[rtl/mmd_front.sv]
// Front part: accepts message items, packs bytes little-endian into words
// and pads the final word. Depends on mmd_pkg and mmd_msg_if.
module mmd_front
    import mmd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    mmd_msg_if.sink    msg,
    input  logic       clear,
    input  logic       q_full,
    output logic       q_push,
    output mmd_word_t  q_data
);

    logic [23:0] partial_word_reg;
    logic [23:0] partial_word_next;
    logic [1:0]  partial_count_reg;
    logic [1:0]  partial_count_next;
    logic        accept;
    logic [4:0]  shift;
    logic [31:0] byte_word;
    logic [31:0] pad_word;

    // Take an item whenever the queue has room
    assign msg.ready = !q_full;
    assign accept    = msg.valid && msg.ready;

    // Place the new byte, or the pad byte, above the pending bytes
    assign shift     = {partial_count_reg, 3'b000};
    assign byte_word = {8'h00, partial_word_reg} | ({24'h0, msg.data_byte} << shift);
    assign pad_word  = {8'h00, partial_word_reg} | ({24'h0, MIC_PAD_BYTE} << shift);

    // Push a full word, or the padded word on finish
    always_comb
    begin
        q_push      = 1'b0;
        q_data.word = byte_word;
        q_data.fin  = 1'b0;
        if (accept)
        begin
            if (msg.op == OP_FINISH)
            begin
                q_push      = 1'b1;
                q_data.word = pad_word;
                q_data.fin  = 1'b1;
            end
            else if (partial_count_reg == 2'd3)
            begin
                q_push = 1'b1;
            end
        end
    end

    // Advance the pending bytes
    always_comb
    begin
        partial_word_next  = partial_word_reg;
        partial_count_next = partial_count_reg;
        if (clear)
        begin
            partial_word_next  = '0;
            partial_count_next = '0;
        end
        else if (accept)
        begin
            if (msg.op == OP_FINISH || partial_count_reg == 2'd3)
            begin
                partial_word_next  = '0;
                partial_count_next = '0;
            end
            else
            begin
                partial_word_next  = byte_word[23:0];
                partial_count_next = partial_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_word_reg  <= '0;
            partial_count_reg <= '0;
        end
        else
        begin
            partial_word_reg  <= partial_word_next;
            partial_count_reg <= partial_count_next;
        end
    end

endmodule

[rtl/mmd_fifo.sv]
// Short word queue between the front and back parts.
// Depends on mmd_pkg.
module mmd_fifo
    import mmd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  mmd_word_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output mmd_word_t pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    mmd_word_t     entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full      = (count_reg == FULL_COUNT);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/mmd_back.sv]
// Back part: holds the key and the two state halves, runs the Michael block
// one round per cycle and drives the MIC output register.
// Depends on mmd_pkg and mmd_mic_if.
module mmd_back
    import mmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  mmd_key_wr_t key_wr,
    input  logic        q_valid,
    input  mmd_word_t   q_data,
    output logic        q_pop,
    mmd_mic_if.source   mic
);

    mmd_state_t  state_reg;
    mmd_state_t  state_next;
    logic [1:0]  round_reg;
    logic [1:0]  round_next;
    logic        fin_reg;
    logic        fin_next;
    logic [31:0] key_low_reg;
    logic [31:0] key_low_next;
    logic [31:0] key_high_reg;
    logic [31:0] key_high_next;
    logic [31:0] left_reg;
    logic [31:0] left_next;
    logic [31:0] right_reg;
    logic [31:0] right_next;
    logic        mic_valid_reg;
    logic        mic_valid_next;
    logic [31:0] mic_low_reg;
    logic [31:0] mic_high_reg;

    logic        run;
    logic        emit;
    logic        reload;
    logic        block_end;
    logic        out_free;
    logic        key_hit;
    logic [63:0] rnd;
    logic [31:0] run_l;
    logic [31:0] run_r;
    logic [31:0] base_l;
    logic [31:0] base_r;

    assign block_end = (round_reg == 2'd3);
    assign out_free  = !mic_valid_reg || mic.ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_BLOCK1;
                end
            end
            ST_BLOCK1:
            begin
                if (block_end)
                begin
                    if (fin_reg)
                    begin
                        state_next = ST_BLOCK2;
                    end
                    else
                    begin
                        state_next = q_valid ? ST_BLOCK1 : ST_IDLE;
                    end
                end
            end
            ST_BLOCK2:
            begin
                if (block_end)
                begin
                    if (out_free)
                    begin
                        state_next = q_valid ? ST_BLOCK1 : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = q_valid ? ST_BLOCK1 : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        run    = 1'b0;
        emit   = 1'b0;
        reload = 1'b0;
        q_pop  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                q_pop = q_valid;
            end
            ST_BLOCK1:
            begin
                run = 1'b1;
                if (block_end && !fin_reg)
                begin
                    q_pop = q_valid;
                end
            end
            ST_BLOCK2:
            begin
                run = 1'b1;
                if (block_end && out_free)
                begin
                    emit   = 1'b1;
                    reload = 1'b1;
                    q_pop  = q_valid;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    emit   = 1'b1;
                    reload = 1'b1;
                    q_pop  = q_valid;
                end
            end
            default:
            begin
                run = 1'b0;
            end
        endcase
    end

    // One round of the block function on the current halves
    assign rnd   = mmd_round(left_reg, right_reg, round_reg);
    assign run_l = run ? rnd[63:32] : left_reg;
    assign run_r = run ? rnd[31:0]  : right_reg;

    // Reload from the key after a MIC leaves, else keep the round result
    assign base_l = reload ? key_low_reg  : run_l;
    assign base_r = reload ? key_high_reg : run_r;

    assign key_hit = key_wr.we &&
                     (key_wr.index == REG_KEY_LOW || key_wr.index == REG_KEY_HIGH);

    // Key registers and state halves; a key write reloads both halves from the key
    always_comb
    begin
        key_low_next  = key_low_reg;
        key_high_next = key_high_reg;
        left_next     = base_l ^ (q_pop ? q_data.word : 32'h0);
        right_next    = base_r;
        if (key_hit)
        begin
            if (key_wr.index == REG_KEY_LOW)
            begin
                key_low_next = key_wr.data;
            end
            else
            begin
                key_high_next = key_wr.data;
            end
            left_next  = key_low_next;
            right_next = key_high_next;
        end
    end

    assign round_next     = run ? round_reg + 2'd1 : round_reg;
    assign fin_next       = q_pop ? q_data.fin : fin_reg;
    assign mic_valid_next = emit ? 1'b1 : (mic.ready ? 1'b0 : mic_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            fin_reg       <= 1'b0;
            key_low_reg   <= '0;
            key_high_reg  <= '0;
            left_reg      <= '0;
            right_reg     <= '0;
            mic_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            fin_reg       <= fin_next;
            key_low_reg   <= key_low_next;
            key_high_reg  <= key_high_next;
            left_reg      <= left_next;
            right_reg     <= right_next;
            mic_valid_reg <= mic_valid_next;
        end
    end

    // Capture the finished halves into the output register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            mic_low_reg  <= run_l;
            mic_high_reg <= run_r;
        end
    end

    assign mic.valid         = mic_valid_reg;
    assign mic.mic_low_word  = mic_low_reg;
    assign mic.mic_high_word = mic_high_reg;

endmodule

[rtl/michael_mic_digest_core.sv]
// Top level of the Michael MIC digest core: front packer, word queue and
// block engine. Depends on mmd_pkg, the channel interfaces and the submodules.
//
// Computes the Michael keyed MIC (TKIP) over a byte stream. Each msg item is
// a message byte (op 0) or a finish command (op 1); a finish returns one
// result with the 64-bit MIC and restarts the message from the key. The front
// part takes one item per cycle while the queue has room and packs bytes into
// 32-bit words; the back part runs the block function one round per cycle
// through a single 32-bit adder, and a byte stream is sustained at one byte
// per cycle until the queue fills. A finish runs two blocks in the engine and
// then goes into the output register, which holds the MIC until it is taken
// while the front keeps accepting bytes into a QUEUE_DEPTH-word queue.
// Key writes (index 0 low word, 1 high word, others ignored) are taken at
// once and reload the state; write them only while no message is in flight.
module michael_mic_digest_core
    import mmd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    mmd_msg_if.sink   msg,
    mmd_cfg_if.sink   cfg,
    mmd_mic_if.source mic
);

    mmd_key_wr_t key_wr;
    mmd_word_t   push_data;
    mmd_word_t   pop_data;
    logic        push;
    logic        full;
    logic        pop;
    logic        pop_valid;
    logic        key_clear;

    // Take key writes every cycle
    assign cfg.ready    = 1'b1;
    assign key_wr.we    = cfg.valid;
    assign key_wr.index = cfg.index;
    assign key_wr.data  = cfg.data;

    // Drop pending bytes only on a write to a key register
    assign key_clear = cfg.valid &&
                       (cfg.index == REG_KEY_LOW || cfg.index == REG_KEY_HIGH);

    mmd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg),
        .clear  (key_clear),
        .q_full (full),
        .q_push (push),
        .q_data (push_data)
    );

    mmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_data  (pop_data)
    );

    mmd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .key_wr  (key_wr),
        .q_valid (pop_valid),
        .q_data  (pop_data),
        .q_pop   (pop),
        .mic     (mic)
    );

endmodule
